[hw/rtl/tcsm_pkg.sv]
// ----------------------------------------------------------------------------
// tcsm_pkg
// Shared types and constants for the touch contact slot map.
// ----------------------------------------------------------------------------
package tcsm_pkg;

  // Default number of contact slots
  localparam int SLOT_COUNT_DEF = 10;

  // Field widths
  localparam int ID_W     = 32;
  localparam int RAW_W    = 32;
  localparam int ORIGIN_W = 17;
  localparam int PIX_W    = 26;
  localparam int SLOT_W   = 4;

  // Reciprocal for unsigned 32-bit division by 100: q = (a * MAGIC) >> SHIFT
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int          DIV100_SHIFT = 37;
  localparam int          QUOT_W       = 25;

  // Configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  // Event kinds
  typedef enum logic [1:0] {
    OP_UP   = 2'd0,
    OP_DOWN = 2'd1,
    OP_MOVE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Slot scan sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_OUT
  } scan_state_t;

  // Pixel conversion sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_Y,
    PH_FIN
  } conv_phase_t;

  // Conversion result handed to the top level
  typedef struct packed {
    logic                    done;
    logic [PIX_W-1:0]        x;
    logic [PIX_W-1:0]        y;
  } pix_res_t;

endpackage

[hw/rtl/tcsm_slot_mem.sv]
// ----------------------------------------------------------------------------
// tcsm_slot_mem
// Slot identifier memory: one write port, one registered read port, and a
// valid bit per entry so that an entry never written reads as zero (free).
// ----------------------------------------------------------------------------
module tcsm_slot_mem #(
  parameter int SLOT_COUNT = tcsm_pkg::SLOT_COUNT_DEF,
  parameter int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [tcsm_pkg::ID_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [tcsm_pkg::ID_W-1:0] wr_data
);

  logic [tcsm_pkg::ID_W-1:0] mem_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]     vld_r;
  logic [tcsm_pkg::ID_W-1:0] rd_q_r;
  logic                      rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Mark entries once written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem_r[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Unwritten entries read as free
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[hw/rtl/tcsm_pixel_conv.sv]
// ----------------------------------------------------------------------------
// tcsm_pixel_conv
// Converts hundredths of a pixel to window-relative whole pixels. One shared
// 32x32 reciprocal multiplier handles x then y; the sign is restored and the
// window origin subtracted in a final step.
// ----------------------------------------------------------------------------
module tcsm_pixel_conv (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [tcsm_pkg::RAW_W-1:0]           raw_x,
  input  logic [tcsm_pkg::RAW_W-1:0]           raw_y,
  input  logic [tcsm_pkg::ORIGIN_W-1:0]        origin_x,
  input  logic [tcsm_pkg::ORIGIN_W-1:0]        origin_y,
  output tcsm_pkg::pix_res_t                   res
);

  localparam int QW  = tcsm_pkg::QUOT_W;
  localparam int PW  = tcsm_pkg::PIX_W;
  localparam int OW  = tcsm_pkg::ORIGIN_W;
  localparam int SH  = tcsm_pkg::DIV100_SHIFT;

  tcsm_pkg::conv_phase_t phase_r, phase_nxt;

  logic                          neg_x_r, neg_y_r;
  logic [tcsm_pkg::RAW_W-1:0]    mag_x_r, mag_y_r;
  logic [QW-1:0]                 q_x_r, q_y_r;
  logic [PW-1:0]                 pix_x_r, pix_y_r;
  logic                          done_r, done_nxt;

  logic [tcsm_pkg::RAW_W-1:0]    mul_a;
  logic [63:0]                   prod;
  logic [QW-1:0]                 quot;
  logic [PW-1:0]                 sx, sy;

  // Shared reciprocal multiplier
  assign mul_a = (phase_r == tcsm_pkg::PH_Y) ? mag_y_r : mag_x_r;
  assign prod  = {32'b0, mul_a} * {32'b0, tcsm_pkg::DIV100_MAGIC};
  assign quot  = prod[SH+QW-1:SH];

  // Restore sign of each quotient
  assign sx = neg_x_r ? (~{1'b0, q_x_r} + PW'(1)) : {1'b0, q_x_r};
  assign sy = neg_y_r ? (~{1'b0, q_y_r} + PW'(1)) : {1'b0, q_y_r};

  // Phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = done_r;
    if (start) begin
      phase_nxt = tcsm_pkg::PH_X;
      done_nxt  = 1'b0;
    end else begin
      unique case (phase_r)
        tcsm_pkg::PH_IDLE: phase_nxt = tcsm_pkg::PH_IDLE;
        tcsm_pkg::PH_X:    phase_nxt = tcsm_pkg::PH_Y;
        tcsm_pkg::PH_Y:    phase_nxt = tcsm_pkg::PH_FIN;
        tcsm_pkg::PH_FIN: begin
          phase_nxt = tcsm_pkg::PH_IDLE;
          done_nxt  = 1'b1;
        end
        default:           phase_nxt = tcsm_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tcsm_pkg::PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // Capture magnitudes, quotients and final pixels
  always_ff @(posedge clk) begin
    if (start) begin
      neg_x_r <= raw_x[tcsm_pkg::RAW_W-1];
      neg_y_r <= raw_y[tcsm_pkg::RAW_W-1];
      mag_x_r <= raw_x[tcsm_pkg::RAW_W-1] ? (~raw_x + 32'd1) : raw_x;
      mag_y_r <= raw_y[tcsm_pkg::RAW_W-1] ? (~raw_y + 32'd1) : raw_y;
    end
    if (!start && phase_r == tcsm_pkg::PH_X) begin
      q_x_r <= quot;
    end
    if (!start && phase_r == tcsm_pkg::PH_Y) begin
      q_y_r <= quot;
    end
    if (!start && phase_r == tcsm_pkg::PH_FIN) begin
      pix_x_r <= sx - {{(PW-OW){origin_x[OW-1]}}, origin_x};
      pix_y_r <= sy - {{(PW-OW){origin_y[OW-1]}}, origin_y};
    end
  end

  assign res.done = done_r;
  assign res.x    = pix_x_r;
  assign res.y    = pix_y_r;

endmodule

[hw/rtl/touch_contact_slot_map_unit.sv]
// ----------------------------------------------------------------------------
// touch_contact_slot_map_unit
// Maps 32-bit touch contact IDs to slot numbers held in a small memory and
// reports each matched event with its window-relative pixel position.
//
//   channel  dir  handshake              payload
//   in       in   in_tvalid/in_tready    tuser: operation; tdata: id, raw_x, raw_y
//   out      out  out_tvalid/out_tready  tuser: event_kind; tdata: slot, pixel_x/y
//   cfg      in   cfg_wr_en              cfg_index, cfg_wdata (window origin)
//
// The slot memory is scanned one entry per cycle through its single read port.
// An up or down event that hits a slot writes it, then waits for the pixel unit;
// a move scans every slot, a miss returns to idle with no result, and kind none
// starts no scan. Reset clears all slots at once through per-entry valid bits.
// A result waits in the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module touch_contact_slot_map_unit #(
  parameter int SLOT_COUNT = tcsm_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [95:0]                     in_tdata,   // contact_id, raw_x, raw_y
  input  logic [1:0]                      in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [55:0]                     out_tdata,  // slot, pixel_x, pixel_y
  output logic [1:0]                      out_tuser,  // event_kind
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [tcsm_pkg::ORIGIN_W-1:0]   cfg_wdata
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IW = tcsm_pkg::ID_W;

  tcsm_pkg::scan_state_t state_r, state_nxt;
  tcsm_pkg::op_t         op_r;
  tcsm_pkg::pix_res_t    pix;

  logic [IW-1:0]                  id_r;
  logic [tcsm_pkg::ORIGIN_W-1:0]  origin_x_r, origin_y_r;
  logic [AW-1:0]                  cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]                  slot_r, slot_nxt;
  logic                           found_r, found_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [tcsm_pkg::SLOT_W-1:0]    out_slot_r;
  logic [tcsm_pkg::PIX_W-1:0]     out_px_r, out_py_r;
  logic [1:0]                     out_kind_r;

  logic          in_fire;
  logic          conv_start;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_data;
  logic          hit;
  logic          last;
  logic          load_out;

  assign in_tready  = (state_r == tcsm_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign conv_start = in_fire && (tcsm_pkg::op_t'(in_tuser) != tcsm_pkg::OP_NONE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcsm_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        tcsm_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        default:                origin_x_r <= origin_x_r;
      endcase
    end
  end

  // Latch the beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= tcsm_pkg::op_t'(in_tuser);
      id_r <= in_tdata[IW-1:0];
    end
  end

  tcsm_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .ADDR_W     (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data)
  );

  tcsm_pixel_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_start),
    .raw_x    (in_tdata[63:32]),
    .raw_y    (in_tdata[95:64]),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .res      (pix)
  );

  // Compare the entry returned by the memory
  assign hit  = (op_r == tcsm_pkg::OP_DOWN) ? (rd_data == '0) : (rd_data == id_r);
  assign last = (cmp_idx_r == AW'(SLOT_COUNT - 1));

  // Scan sequencer
  always_comb begin
    state_nxt   = state_r;
    cmp_idx_nxt = cmp_idx_r;
    slot_nxt    = slot_r;
    found_nxt   = found_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_data     = id_r;
    load_out    = 1'b0;
    unique case (state_r)
      tcsm_pkg::S_IDLE: begin
        if (conv_start) begin
          rd_en       = 1'b1;
          cmp_idx_nxt = '0;
          found_nxt   = 1'b0;
          state_nxt   = tcsm_pkg::S_SCAN;
        end
      end
      tcsm_pkg::S_SCAN: begin
        rd_en       = !last;
        rd_addr     = cmp_idx_r + AW'(1);
        cmp_idx_nxt = cmp_idx_r + AW'(1);
        case (op_r) inside
          tcsm_pkg::OP_UP, tcsm_pkg::OP_DOWN: begin
            if (hit) begin
              slot_nxt  = cmp_idx_r;
              state_nxt = tcsm_pkg::S_WRITE;
            end else if (last) begin
              state_nxt = tcsm_pkg::S_IDLE;
            end
          end
          tcsm_pkg::OP_MOVE: begin
            if (hit) begin
              slot_nxt  = cmp_idx_r;
              found_nxt = 1'b1;
            end
            if (last) begin
              state_nxt = (hit || found_r) ? tcsm_pkg::S_OUT : tcsm_pkg::S_IDLE;
            end
          end
          default: state_nxt = tcsm_pkg::S_IDLE;
        endcase
      end
      tcsm_pkg::S_WRITE: begin
        wr_en     = 1'b1;
        wr_data   = (op_r == tcsm_pkg::OP_UP) ? '0 : id_r;
        state_nxt = tcsm_pkg::S_OUT;
      end
      tcsm_pkg::S_OUT: begin
        if (pix.done && (!out_valid_r || out_tready)) begin
          load_out  = 1'b1;
          state_nxt = tcsm_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcsm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcsm_pkg::S_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  // Scan pointers
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
  end

  // Output register: hold until taken
  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r <= op_r;
      out_slot_r <= tcsm_pkg::SLOT_W'(slot_r);
      out_px_r   <= pix.x;
      out_py_r   <= pix.y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_py_r, out_px_r, out_slot_r};

endmodule
